/* src/assert_macros.svh */
// assertion macros shared by the porous cell coefficient rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define PCC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcc implication check failed");

// next-cycle implication, quiet during reset
`define PCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcc next-cycle check failed");

`endif

/* src/pcc_pkg.sv */
// types, constants and helpers of the porous cell coefficient block
package pcc_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned COEF_W    = 64;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned FRAC_W    = 16;
    localparam int unsigned SUM_W     = 50;

    typedef logic signed [DATA_W-1:0] q16_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PERM_COEFS     = 3'd0,
        REG_PORO_COEFS     = 3'd1,
        REG_DENS_SLOPE     = 3'd2,
        REG_DENS_OFFSET    = 3'd3,
        REG_VOLUME_OVER_DT = 3'd4,
        REG_INV_VISC       = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [COEF_W-1:0] perm_coefs;
        logic [COEF_W-1:0] poro_coefs;
        q16_t              dens_slope;
        q16_t              dens_offset;
        q16_t              volume_over_dt;
        q16_t              inv_visc;
    } pcc_cfg_t;

    // q8.8 coefficient idx of a packed word as q16.16, zero at or above terms
    function automatic q16_t coef_q16(input logic [COEF_W-1:0] word,
                                      input logic [1:0] idx,
                                      input int unsigned terms);
        logic [15:0] raw;
        raw = word[{idx, 4'b0000} +: 16];
        if (32'(idx) >= terms)
        begin
            return '0;
        end
        return q16_t'({{8{raw[15]}}, raw, 8'h00});
    endfunction

endpackage

/* src/porous_cell_coefficients.sv */
// top level: storage and mobility coefficients of a porous cell per pressure item
//
//   channel   signals                                   direction
//   item      item_valid item_stall pressure            in
//   result    result_valid result_stall alpha_out       out
//             lambda_out saturated
//   config    cfg_valid cfg_ready cfg_index cfg_data    in
//
// one item enters per cycle while item_stall is low; results leave in the order of their items
// five steps of two stages each (multiply, then round/add/clip)
// unused high coefficients are zeroed, so the perm and poro polynomials run three horner steps
// a held result freezes the whole pipeline and raises item_stall the same cycle
// reset clears the valid bits and config registers to zero and empties the pipeline
`include "assert_macros.svh"

module porous_cell_coefficients #(
    parameter int unsigned POLY_TERMS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  pcc_pkg::q16_t                 pressure,
    output logic                          result_valid,
    input  logic                          result_stall,
    output pcc_pkg::q16_t                 alpha_out,
    output pcc_pkg::q16_t                 lambda_out,
    output logic                          saturated,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pcc_pkg::COEF_W-1:0]    cfg_data
);
    import pcc_pkg::*;

    localparam int unsigned STEPS   = 5;
    localparam int unsigned MAC_LAT = 2;
    localparam int unsigned STAGES  = STEPS * MAC_LAT;
    localparam int unsigned P_DLY   = 2 * MAC_LAT;
    localparam int unsigned D_DLY   = 2 * MAC_LAT;

    pcc_cfg_t          cfg;
    logic              en;
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    q16_t              p_dly_reg [P_DLY];
    q16_t              dens_dly_reg [D_DLY];

    q16_t perm_c [4];
    q16_t poro_c [4];
    q16_t der_top;
    q16_t der_mid;

    q16_t dens,  perm1, poro1, perm2, poro2, der1, perm3, poro3, der2;
    q16_t t_val, u_val, alpha_val, lambda_val;
    logic dens_f, perm1_f, poro1_f, perm2_f, poro2_f, der1_f, perm3_f, poro3_f, der2_f;
    logic t_f, u_f, alpha_f, lambda_f;
    logic f1, f2, f3, f4;

    pcc_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // coefficients above the term count read as zero
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            perm_c[i] = coef_q16(cfg.perm_coefs, 2'(i), POLY_TERMS);
            poro_c[i] = coef_q16(cfg.poro_coefs, 2'(i), POLY_TERMS);
        end
        der_top = q16_t'(poro_c[3] + (poro_c[3] <<< 1));
        der_mid = q16_t'(poro_c[2] <<< 1);
    end

    assign en         = !(valid_reg[STAGES-1] && result_stall);
    assign item_stall = !en;
    assign valid_next = {valid_reg[STAGES-2:0], item_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    // pressure and density ride alongside the horner steps
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_dly_reg[0]    <= pressure;
            dens_dly_reg[0] <= dens;
            for (int i = 1; i < P_DLY; i++)
            begin
                p_dly_reg[i] <= p_dly_reg[i-1];
            end
            for (int i = 1; i < D_DLY; i++)
            begin
                dens_dly_reg[i] <= dens_dly_reg[i-1];
            end
        end
    end

    // step 1: density and first horner step
    pcc_mac u_dens (
        .clk(clk), .en(en), .a_val(cfg.dens_slope), .b_val(pressure), .c_val('0),
        .d_val('0), .term_val(cfg.dens_offset), .flag_in(1'b0), .result(dens),
        .flag(dens_f)
    );
    pcc_mac u_perm1 (
        .clk(clk), .en(en), .a_val(perm_c[3]), .b_val(pressure), .c_val('0),
        .d_val('0), .term_val(perm_c[2]), .flag_in(1'b0), .result(perm1),
        .flag(perm1_f)
    );
    pcc_mac u_poro1 (
        .clk(clk), .en(en), .a_val(poro_c[3]), .b_val(pressure), .c_val('0),
        .d_val('0), .term_val(poro_c[2]), .flag_in(1'b0), .result(poro1),
        .flag(poro1_f)
    );
    assign f1 = dens_f | perm1_f | poro1_f;

    // step 2
    pcc_mac u_perm2 (
        .clk(clk), .en(en), .a_val(perm1), .b_val(p_dly_reg[1]), .c_val('0),
        .d_val('0), .term_val(perm_c[1]), .flag_in(f1), .result(perm2),
        .flag(perm2_f)
    );
    pcc_mac u_poro2 (
        .clk(clk), .en(en), .a_val(poro1), .b_val(p_dly_reg[1]), .c_val('0),
        .d_val('0), .term_val(poro_c[1]), .flag_in(1'b0), .result(poro2),
        .flag(poro2_f)
    );
    pcc_mac u_der1 (
        .clk(clk), .en(en), .a_val(der_top), .b_val(p_dly_reg[1]), .c_val('0),
        .d_val('0), .term_val(der_mid), .flag_in(1'b0), .result(der1),
        .flag(der1_f)
    );
    assign f2 = perm2_f | poro2_f | der1_f;

    // step 3
    pcc_mac u_perm3 (
        .clk(clk), .en(en), .a_val(perm2), .b_val(p_dly_reg[3]), .c_val('0),
        .d_val('0), .term_val(perm_c[0]), .flag_in(f2), .result(perm3),
        .flag(perm3_f)
    );
    pcc_mac u_poro3 (
        .clk(clk), .en(en), .a_val(poro2), .b_val(p_dly_reg[3]), .c_val('0),
        .d_val('0), .term_val(poro_c[0]), .flag_in(1'b0), .result(poro3),
        .flag(poro3_f)
    );
    pcc_mac u_der2 (
        .clk(clk), .en(en), .a_val(der1), .b_val(p_dly_reg[3]), .c_val('0),
        .d_val('0), .term_val(poro_c[1]), .flag_in(1'b0), .result(der2),
        .flag(der2_f)
    );
    assign f3 = perm3_f | poro3_f | der2_f;

    // step 4: t = poro*slope + poro'*dens, u = dens*perm
    pcc_mac u_t (
        .clk(clk), .en(en), .a_val(poro3), .b_val(cfg.dens_slope), .c_val(der2),
        .d_val(dens_dly_reg[D_DLY-1]), .term_val('0), .flag_in(f3), .result(t_val),
        .flag(t_f)
    );
    pcc_mac u_u (
        .clk(clk), .en(en), .a_val(dens_dly_reg[D_DLY-1]), .b_val(perm3), .c_val('0),
        .d_val('0), .term_val('0), .flag_in(1'b0), .result(u_val),
        .flag(u_f)
    );
    assign f4 = t_f | u_f;

    // step 5: final scaling, its output registers hold the result
    pcc_mac u_alpha (
        .clk(clk), .en(en), .a_val(t_val), .b_val(cfg.volume_over_dt), .c_val('0),
        .d_val('0), .term_val('0), .flag_in(f4), .result(alpha_val),
        .flag(alpha_f)
    );
    pcc_mac u_lambda (
        .clk(clk), .en(en), .a_val(u_val), .b_val(cfg.inv_visc), .c_val('0),
        .d_val('0), .term_val('0), .flag_in(1'b0), .result(lambda_val),
        .flag(lambda_f)
    );

    assign result_valid = valid_reg[STAGES-1];
    assign alpha_out    = alpha_val;
    assign lambda_out   = lambda_val;
    assign saturated    = alpha_f | lambda_f;

    `PCC_ASSERT_NEXT(a_freeze_holds_valids, clk, rst_n, !en, valid_reg == $past(valid_reg))
    `PCC_ASSERT_IMPLIES(a_stall_only_when_held, clk, rst_n, item_stall, result_valid && result_stall)
    `PCC_ASSERT_NEXT(a_accept_enters_pipe, clk, rst_n, item_valid && !item_stall, valid_reg[0])

endmodule

/* src/pcc_regs.sv */
// configuration register file of the porous cell coefficient block
module pcc_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pcc_pkg::COEF_W-1:0]    cfg_data,
    output pcc_pkg::pcc_cfg_t             cfg
);
    import pcc_pkg::*;

    pcc_cfg_t cfg_reg;
    pcc_cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PERM_COEFS:     cfg_next.perm_coefs     = cfg_data;
                REG_PORO_COEFS:     cfg_next.poro_coefs     = cfg_data;
                REG_DENS_SLOPE:     cfg_next.dens_slope     = q16_t'(cfg_data[DATA_W-1:0]);
                REG_DENS_OFFSET:    cfg_next.dens_offset    = q16_t'(cfg_data[DATA_W-1:0]);
                REG_VOLUME_OVER_DT: cfg_next.volume_over_dt = q16_t'(cfg_data[DATA_W-1:0]);
                REG_INV_VISC:       cfg_next.inv_visc       = q16_t'(cfg_data[DATA_W-1:0]);
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/pcc_mac.sv */
// two-stage multiply, round, add and saturate unit
module pcc_mac (
    input  logic          clk,
    input  logic          en,
    input  pcc_pkg::q16_t a_val,
    input  pcc_pkg::q16_t b_val,
    input  pcc_pkg::q16_t c_val,
    input  pcc_pkg::q16_t d_val,
    input  pcc_pkg::q16_t term_val,
    input  logic          flag_in,
    output pcc_pkg::q16_t result,
    output logic          flag
);
    import pcc_pkg::*;

    localparam int unsigned PROD_W = 2 * DATA_W;
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_W - 1);
    localparam logic signed [SUM_W-1:0] SAT_MAX =
        {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_MIN =
        {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    logic signed [PROD_W-1:0] prod_ab_reg;
    logic signed [PROD_W-1:0] prod_cd_reg;
    q16_t                     term_reg;
    logic                     flag_a_reg;
    logic signed [PROD_W-1:0] rnd_ab;
    logic signed [PROD_W-1:0] rnd_cd;
    logic signed [SUM_W-1:0]  sum;
    q16_t                     result_reg;
    q16_t                     result_next;
    logic                     flag_reg;
    logic                     flag_next;

    // stage a: exact products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_ab_reg <= PROD_W'(a_val) * PROD_W'(b_val);
            prod_cd_reg <= PROD_W'(c_val) * PROD_W'(d_val);
            term_reg    <= term_val;
            flag_a_reg  <= flag_in;
        end
    end

    // stage b: round half up to q16.16, add, clip once
    always_comb
    begin
        rnd_ab = (prod_ab_reg + RND_HALF) >>> FRAC_W;
        rnd_cd = (prod_cd_reg + RND_HALF) >>> FRAC_W;
        sum    = SUM_W'(rnd_ab) + SUM_W'(rnd_cd) + SUM_W'(term_reg);
        if (sum > SAT_MAX)
        begin
            result_next = q16_t'(SAT_MAX[DATA_W-1:0]);
            flag_next   = 1'b1;
        end
        else if (sum < SAT_MIN)
        begin
            result_next = q16_t'(SAT_MIN[DATA_W-1:0]);
            flag_next   = 1'b1;
        end
        else
        begin
            result_next = q16_t'(sum[DATA_W-1:0]);
            flag_next   = flag_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
            flag_reg   <= flag_next;
        end
    end

    assign result = result_reg;
    assign flag   = flag_reg;

endmodule

/* dv/porous_cell_coefficients_test.sv */
// self-checking testbench for porous_cell_coefficients: directed table, then random phases
`timescale 1ns / 1ps

module porous_cell_coefficients_test;
    import pcc_pkg::*;

    localparam int unsigned TERMS     = 4;
    localparam int          PLAN_ROWS = 33;
    localparam int          PHASES    = 5;
    localparam int          PHASE_LEN = 110;
    localparam int          SETTLE    = 20;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam q16_t   P_MAX    = 32'sh7fff_ffff;
    localparam q16_t   P_MIN    = 32'sh8000_0000;
    localparam q16_t   P_ONE    = 32'sh0001_0000;
    localparam longint WIDE_MAX = 64'sh0000_0000_7fff_ffff;
    localparam longint WIDE_MIN = -WIDE_MAX - 1;
    localparam int unsigned PRESSURE_SPREAD = 32'h0004_0000;
    localparam int unsigned CFG_SPREAD      = 32'h0002_0000;

    typedef struct packed {
        q16_t alpha;
        q16_t lambda;
        logic saturated;
    } cell_result_t;

    typedef enum logic {ROW_WRITE, ROW_CELL} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] index;
        logic [COEF_W-1:0]    value;
        logic                 typed;
        cell_result_t         want;
    } plan_row_t;

    typedef enum {VALS_MODEST, VALS_FULL, VALS_EXTREME, VALS_MIXED} value_style_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_stall;
    q16_t                 pressure     = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    q16_t                 alpha_out;
    q16_t                 lambda_out;
    logic                 saturated;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [COEF_W-1:0]    cfg_data     = '0;

    // typed-in expectation riding along with the item being offered
    logic         typed_next = 1'b0;
    cell_result_t typed_want = '0;

    bit           steady = 1'b0;
    pcc_cfg_t     regs   = '0;
    cell_result_t pending_coefs [$];
    int           mismatches   = 0;
    int           results_seen = 0;
    plan_row_t    plan [PLAN_ROWS];

    porous_cell_coefficients #(
        .POLY_TERMS(TERMS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .pressure    (pressure),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .alpha_out   (alpha_out),
        .lambda_out  (lambda_out),
        .saturated   (saturated),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // fixed-point predictor

    function automatic longint qmul(input longint a, input longint b);
        return (a * b + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
    endfunction

    function automatic longint clip32(input longint x, inout bit clipped);
        if (x > WIDE_MAX)
        begin
            clipped = 1'b1;
            return WIDE_MAX;
        end
        if (x < WIDE_MIN)
        begin
            clipped = 1'b1;
            return WIDE_MIN;
        end
        return x;
    endfunction

    // q8.8 coefficient i of a packed word, widened to q16.16
    function automatic longint coef_at(input logic [COEF_W-1:0] word, input int i);
        logic signed [15:0] raw;
        raw = word[16*i +: 16];
        return longint'(raw) <<< 8;
    endfunction

    // polynomial value, or its derivative when slope_of is set
    function automatic longint horner(input logic [COEF_W-1:0] word, input longint p,
                                      input bit slope_of, inout bit clipped);
        longint acc;
        int     low;
        low = slope_of ? 1 : 0;
        // a single-term polynomial has a zero derivative
        if (int'(TERMS) - 1 < low)
        begin
            return 0;
        end
        acc = (slope_of ? longint'(TERMS - 1) : 64'sd1) * coef_at(word, TERMS - 1);
        for (int i = TERMS - 2; i >= low; i--)
        begin
            acc = clip32(qmul(acc, p) + (slope_of ? longint'(i) : 64'sd1) * coef_at(word, i),
                         clipped);
        end
        return acc;
    endfunction

    function automatic cell_result_t cell_coefs(input q16_t p, input pcc_cfg_t r);
        bit     clipped;
        longint dens;
        longint perm;
        longint poro;
        longint dporo;
        longint t;
        longint u;
        longint a;
        longint l;
        clipped = 1'b0;
        dens  = clip32(qmul(r.dens_slope, p) + longint'(r.dens_offset), clipped);
        perm  = horner(r.perm_coefs, p, 1'b0, clipped);
        poro  = horner(r.poro_coefs, p, 1'b0, clipped);
        dporo = horner(r.poro_coefs, p, 1'b1, clipped);
        t = clip32(qmul(poro, r.dens_slope) + qmul(dporo, dens), clipped);
        a = clip32(qmul(t, r.volume_over_dt), clipped);
        u = clip32(qmul(dens, perm), clipped);
        l = clip32(qmul(u, r.inv_visc), clipped);
        return '{alpha: a[31:0], lambda: l[31:0], saturated: clipped};
    endfunction

    // ------------------------------------------------------------------
    // item tracking, register mirror and result checking

    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
        begin
            pending_coefs.insert(pending_coefs.size(),
                                 typed_next ? typed_want : cell_coefs(pressure, regs));
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PERM_COEFS:     regs.perm_coefs     = cfg_data;
                REG_PORO_COEFS:     regs.poro_coefs     = cfg_data;
                REG_DENS_SLOPE:     regs.dens_slope     = cfg_data[DATA_W-1:0];
                REG_DENS_OFFSET:    regs.dens_offset    = cfg_data[DATA_W-1:0];
                REG_VOLUME_OVER_DT: regs.volume_over_dt = cfg_data[DATA_W-1:0];
                REG_INV_VISC:       regs.inv_visc       = cfg_data[DATA_W-1:0];
                default:            ;
            endcase
        end
    end

    always @(posedge clk)
    begin : check_results
        cell_result_t want;
        cell_result_t got;
        if (rst_n && result_valid && !result_stall)
        begin
            got = {alpha_out, lambda_out, saturated};
            if (pending_coefs.size() == 0)
            begin
                if (mismatches < 10)
                begin
                    $display("result %0d arrived with none outstanding: %s %h %h sat %b",
                             results_seen, "alpha/lambda", got.alpha, got.lambda,
                             got.saturated);
                end
                mismatches++;
            end
            else
            begin
                want = pending_coefs.pop_front();
                if (want !== got)
                begin
                    if (mismatches < 10)
                    begin
                        $display("result %0d: alpha exp %h got %h, lambda exp %h got %h,",
                                 results_seen, want.alpha, got.alpha, want.lambda,
                                 got.lambda);
                        $display("    sat exp %b got %b", want.saturated, got.saturated);
                    end
                    mismatches++;
                end
            end
            results_seen++;
        end
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        result_stall <= !steady && ($urandom_range(99) < 17);
    end

    // ------------------------------------------------------------------
    // stimulus helpers

    function automatic plan_row_t write_row(input logic [CFG_IDX_W-1:0] index,
                                            input logic [COEF_W-1:0] data);
        return '{kind: ROW_WRITE, index: index, value: data, typed: 1'b0, want: '0};
    endfunction

    function automatic plan_row_t cell_row(input q16_t p);
        return '{kind: ROW_CELL, index: '0, value: {32'h0, p}, typed: 1'b0, want: '0};
    endfunction

    function automatic plan_row_t typed_row(input q16_t p, input q16_t a, input q16_t l,
                                            input logic s);
        return '{kind: ROW_CELL, index: '0, value: {32'h0, p}, typed: 1'b1,
                 want: '{alpha: a, lambda: l, saturated: s}};
    endfunction

    function automatic value_style_t settle(input value_style_t s);
        if (s != VALS_MIXED)
        begin
            return s;
        end
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return VALS_MODEST;
            6, 7:             return VALS_FULL;
            default:          return VALS_EXTREME;
        endcase
    endfunction

    function automatic q16_t draw_q16(input value_style_t s, input int unsigned spread);
        case (settle(s))
            VALS_FULL: return $urandom;
            VALS_EXTREME:
            begin
                case ($urandom_range(4))
                    0:       return P_MAX;
                    1:       return P_MIN;
                    2:       return '0;
                    3:       return P_ONE;
                    default: return -P_ONE;
                endcase
            end
            default: return int'($urandom_range(2 * spread)) - int'(spread);
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] draw_coefs(input value_style_t s);
        logic [COEF_W-1:0] word;
        logic [15:0]       h;
        for (int k = 0; k < 4; k++)
        begin
            case (settle(s))
                VALS_FULL: h = $urandom;
                VALS_EXTREME:
                begin
                    case ($urandom_range(4))
                        0:       h = 16'h7fff;
                        1:       h = 16'h8000;
                        2:       h = 16'h0000;
                        3:       h = 16'h0100;
                        default: h = 16'hff00;
                    endcase
                end
                // within about two in q8.8
                default: h = 16'(int'($urandom_range(1024)) - 512);
            endcase
            word[16*k +: 16] = h;
        end
        return word;
    endfunction

    task automatic send_cell(input q16_t p, input logic typed, input cell_result_t want);
        while (!steady && $urandom_range(99) < 17)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        pressure   <= p;
        typed_next <= typed;
        typed_want <= want;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [COEF_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    // stop offering items and let every outstanding result come back
    task automatic wait_for_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_coefs.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic load_config(input value_style_t s);
        wait_for_results();
        write_reg(REG_PERM_COEFS, draw_coefs(s));
        write_reg(REG_PORO_COEFS, draw_coefs(s));
        write_reg(REG_DENS_SLOPE, {$urandom, draw_q16(s, CFG_SPREAD)});
        if (s == VALS_MIXED)
        begin
            write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, {$urandom, $urandom});
        end
        write_reg(REG_DENS_OFFSET, {$urandom, draw_q16(s, CFG_SPREAD)});
        write_reg(REG_VOLUME_OVER_DT, {$urandom, draw_q16(s, CFG_SPREAD)});
        write_reg(REG_INV_VISC, {$urandom, draw_q16(s, CFG_SPREAD)});
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // run

    initial
    begin : stimulus
        bit           writing;
        value_style_t style;
        writing = 1'b0;
        plan = '{
            // all registers zero after reset
            typed_row(32'sh0, '0, '0, 1'b0),
            typed_row(P_MAX, '0, '0, 1'b0),
            typed_row(P_MIN, '0, '0, 1'b0),
            // density clips at both pressure extremes, results stay zero but flagged
            write_row(REG_DENS_SLOPE, {32'ha5a5_5a5a, P_MAX}),
            typed_row(P_MAX, '0, '0, 1'b1),
            typed_row(P_MIN, '0, '0, 1'b1),
            typed_row(32'sh0, '0, '0, 1'b0),
            // coefficient and register extremes
            write_row(REG_PERM_COEFS, 64'h7fff_8000_0100_ffff),
            write_row(REG_PORO_COEFS, 64'h8000_7fff_ffff_0100),
            write_row(REG_DENS_SLOPE, {32'hffff_ffff, P_ONE}),
            write_row(REG_DENS_OFFSET, {32'h0, P_MAX}),
            write_row(REG_VOLUME_OVER_DT, {32'h1234_5678, P_MIN}),
            write_row(REG_INV_VISC, {32'h0, P_ONE}),
            cell_row(32'sh0),
            cell_row(P_ONE),
            cell_row(-P_ONE),
            cell_row(32'sh1),
            cell_row(-32'sh1),
            cell_row(P_MAX),
            cell_row(P_MIN),
            // writes past the register list must leave everything as it was
            write_row(REG_SPARE_LO, '1),
            write_row(REG_SPARE_HI, '1),
            cell_row(32'sh0002_0000),
            cell_row(-32'sh0001_8000),
            // moderate physical values
            write_row(REG_PERM_COEFS, 64'h0000_0000_0080_0100),
            write_row(REG_PORO_COEFS, 64'h0008_0010_0020_0040),
            write_row(REG_DENS_SLOPE, {32'h0, 32'h0000_4000}),
            write_row(REG_DENS_OFFSET, {32'h0, P_ONE}),
            write_row(REG_VOLUME_OVER_DT, {32'h0, 32'h0002_0000}),
            write_row(REG_INV_VISC, {32'h0, 32'h0000_8000}),
            cell_row(32'sh0003_0000),
            cell_row(-32'sh0003_0000),
            cell_row(32'sh0000_8000)
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < PLAN_ROWS; k++)
        begin
            if (plan[k].kind == ROW_WRITE)
            begin
                if (!writing)
                begin
                    wait_for_results();
                end
                write_reg(plan[k].index, plan[k].value);
                writing = 1'b1;
            end
            else
            begin
                if (writing)
                begin
                    cfg_valid <= 1'b0;
                end
                writing = 1'b0;
                send_cell(plan[k].value[DATA_W-1:0], plan[k].typed, plan[k].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                1:       style = VALS_FULL;
                3:       style = VALS_EXTREME;
                4:       style = VALS_MIXED;
                default: style = VALS_MODEST;
            endcase
            load_config(style);
            // one phase runs back to back with no gaps on either side
            steady = (ph == 2);
            repeat (PHASE_LEN) send_cell(draw_q16(VALS_MIXED, PRESSURE_SPREAD), 1'b0, '0);
        end
        steady = 1'b0;

        wait_for_results();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && pending_coefs.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/pcc_pkg.sv
src/pcc_regs.sv
src/pcc_mac.sv
src/porous_cell_coefficients.sv
dv/porous_cell_coefficients_test.sv
